FILE: rtl/layered_sprite_compositor_defines.svh
// Assertion macros shared by the layered sprite compositor modules.
// Depends on nothing; the including module provides clk and rst.
`ifndef LAYERED_SPRITE_COMPOSITOR_DEFINES_SVH
`define LAYERED_SPRITE_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lsc_pkg.sv
// Package for the layered sprite compositor: board geometry, cell entry layout,
// controller states and the command and status structs. Depends on nothing.
package lsc_pkg;

  localparam int BOARD_ROWS = 64;
  localparam int BOARD_COLS = 64;
  localparam int CELLS = BOARD_ROWS * BOARD_COLS;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [7:0] GLYPH_EMPTY = 8'd46;
  localparam logic [6:0] EXTENT_MAX = 7'd127;
  localparam logic CMD_DRAW = 1'b0;

  typedef struct packed {
    logic        used;
    logic [7:0]  glyph;
    logic [15:0] layer;
    logic [63:0] name;
  } cell_entry_t;

  localparam int ENTRY_W = $bits(cell_entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REQ,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic clear_we;
    logic latch;
    logic rd_en;
    logic resolve;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_status_t;

  function automatic logic [6:0] widen(input logic [6:0] cur, input logic [6:0] pos);
    logic [7:0] need;
    logic [6:0] sat;
    need = {1'b0, pos} + 8'd1;
    sat = (need > {1'b0, EXTENT_MAX}) ? EXTENT_MAX : need[6:0];
    return (sat > cur) ? sat : cur;
  endfunction

endpackage

FILE: rtl/lsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lsc_ctrl.sv
// Controller state machine of the layered sprite compositor.
// Depends on lsc_pkg and the assertion macro header.
`include "layered_sprite_compositor_defines.svh"

module lsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lsc_pkg::ctrl_status_t status,
  output lsc_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  lsc_pkg::ctrl_state_t state;
  lsc_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      lsc_pkg::ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = lsc_pkg::ST_IDLE;
        end
      end
      lsc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_next = lsc_pkg::ST_REQ;
        end
      end
      lsc_pkg::ST_REQ: begin
        cmd.rd_en = 1'b1;
        state_next = lsc_pkg::ST_RESP;
      end
      lsc_pkg::ST_RESP: begin
        cmd.resolve = 1'b1;
        state_next = lsc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lsc_pkg::ST_CLEAR;
      end
    endcase
  end

  `LSC_ASSERT_NEXT(a_accept_reads, start && !busy, state == lsc_pkg::ST_REQ, "item not read")
  `LSC_ASSERT_NEXT(a_req_resp, state == lsc_pkg::ST_REQ, state == lsc_pkg::ST_RESP, "read lost")
  `LSC_ASSERT_NOW(a_one_cmd, cmd.clear_we, !cmd.resolve && !cmd.latch, "clear overlaps item")

endmodule

FILE: rtl/lsc_datapath.sv
// Datapath of the layered sprite compositor: input registers, cell store,
// depth test, extent registers and the result registers.
// Depends on lsc_pkg, lsc_ram and the assertion macro header.
`include "layered_sprite_compositor_defines.svh"

module lsc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  lsc_pkg::ctrl_cmd_t    cmd,
  output lsc_pkg::ctrl_status_t status,
  input  logic                  command,
  input  logic [6:0]            row,
  input  logic [6:0]            col,
  input  logic [7:0]            pixel_char,
  input  logic signed [15:0]    layer_depth,
  input  logic [63:0]           name_key,
  output logic [7:0]            cell_char,
  output logic [6:0]            board_rows,
  output logic [6:0]            board_cols,
  output logic                  dropped,
  output logic                  done
);

  logic                        command_q;
  logic [6:0]                  row_q;
  logic [6:0]                  col_q;
  logic [7:0]                  char_q;
  logic signed [15:0]          depth_q;
  logic [63:0]                 key_q;
  logic [lsc_pkg::CELL_AW-1:0] clear_cnt;
  logic [6:0]                  ext_rows;
  logic [6:0]                  ext_cols;
  logic [6:0]                  ext_rows_next;
  logic [6:0]                  ext_cols_next;
  logic                        in_board;
  logic [14:0]                 idx_full;
  logic [lsc_pkg::CELL_AW-1:0] cell_addr;
  lsc_pkg::cell_entry_t        rd_entry;
  lsc_pkg::cell_entry_t        new_entry;
  logic                        win;
  logic                        paint;
  logic                        ram_we;
  logic [lsc_pkg::CELL_AW-1:0] ram_waddr;
  logic [lsc_pkg::ENTRY_W-1:0] ram_wdata;
  logic [7:0]                  glyph;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      command_q <= command;
      row_q <= row;
      col_q <= col;
      char_q <= pixel_char;
      depth_q <= layer_depth;
      key_q <= name_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear_we) begin
      clear_cnt <= clear_cnt + 1'b1;
    end
  end

  assign status.clear_last = (clear_cnt == lsc_pkg::CELL_AW'(lsc_pkg::CELLS - 1));

  assign in_board = ({1'b0, row_q} < 8'(lsc_pkg::BOARD_ROWS)) &&
                    ({1'b0, col_q} < 8'(lsc_pkg::BOARD_COLS));
  assign idx_full = 15'(row_q) * 15'(lsc_pkg::BOARD_COLS) + 15'(col_q);
  assign cell_addr = in_board ? idx_full[lsc_pkg::CELL_AW-1:0] : '0;

  lsc_ram #(
    .WIDTH(lsc_pkg::ENTRY_W),
    .DEPTH(lsc_pkg::CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(cell_addr),
    .rdata(rd_entry)
  );

  always_comb begin
    win = !rd_entry.used ||
          (depth_q < $signed(rd_entry.layer)) ||
          ((depth_q == $signed(rd_entry.layer)) && (key_q > rd_entry.name));
    paint = cmd.resolve && in_board && (command_q == lsc_pkg::CMD_DRAW) &&
            (char_q != lsc_pkg::GLYPH_EMPTY) && win;
    new_entry.used = 1'b1;
    new_entry.glyph = char_q;
    new_entry.layer = depth_q;
    new_entry.name = key_q;
    ram_we = cmd.clear_we || paint;
    ram_waddr = cmd.clear_we ? clear_cnt : cell_addr;
    ram_wdata = cmd.clear_we ? '0 : new_entry;
    if (!in_board) begin
      glyph = lsc_pkg::GLYPH_EMPTY;
    end else if (paint) begin
      glyph = char_q;
    end else if (rd_entry.used) begin
      glyph = rd_entry.glyph;
    end else begin
      glyph = lsc_pkg::GLYPH_EMPTY;
    end
    ext_rows_next = ext_rows;
    ext_cols_next = ext_cols;
    if (in_board && (command_q == lsc_pkg::CMD_DRAW)) begin
      ext_rows_next = lsc_pkg::widen(ext_rows, row_q);
      ext_cols_next = lsc_pkg::widen(ext_cols, col_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_rows <= '0;
      ext_cols <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.resolve;
      if (cmd.resolve) begin
        ext_rows <= ext_rows_next;
        ext_cols <= ext_cols_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      cell_char <= glyph;
      board_rows <= ext_rows_next;
      board_cols <= ext_cols_next;
      dropped <= !in_board;
    end
  end

  `LSC_ASSERT_NEXT(a_resolve_done, cmd.resolve, done, "result strobe missing")
  `LSC_ASSERT_NEXT(a_done_single, done, !done, "result strobe held")
  `LSC_ASSERT_NOW(a_drop_empty, done && dropped, cell_char == lsc_pkg::GLYPH_EMPTY, "bad drop")

endmodule

FILE: rtl/layered_sprite_compositor.sv
// Each item is accepted at an edge while busy is low; the cell store is read in the
// REQ state, and the depth test and write-back follow in the RESP state; done is
// high in the cycle after RESP and the result is taken at the edge that ends it.
// A new item is accepted only once busy falls, as the read-modify-write of the
// single cell store must finish first. After reset, busy stays high while the
// store is cleared one cell per cycle, BOARD_ROWS * BOARD_COLS cells in all.
module layered_sprite_compositor (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [6:0]         row,
  input  logic [6:0]         col,
  input  logic [7:0]         pixel_char,
  input  logic signed [15:0] layer_depth,
  input  logic [63:0]        name_key,
  output logic               done,
  output logic [7:0]         cell_char,
  output logic [6:0]         board_rows,
  output logic [6:0]         board_cols,
  output logic               dropped
);

  lsc_pkg::ctrl_cmd_t    cmd;
  lsc_pkg::ctrl_status_t status;

  lsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  lsc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (command),
    .row        (row),
    .col        (col),
    .pixel_char (pixel_char),
    .layer_depth(layer_depth),
    .name_key   (name_key),
    .cell_char  (cell_char),
    .board_rows (board_rows),
    .board_cols (board_cols),
    .dropped    (dropped),
    .done       (done)
  );

endmodule
